@@ hdl/csv_telemetry_field_parser_defines.svh @@
// Assertion macros shared by the parser modules.
`ifndef CSV_TELEMETRY_FIELD_PARSER_DEFINES_SVH
`define CSV_TELEMETRY_FIELD_PARSER_DEFINES_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define CSVTP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define CSVTP_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CSVTP_ASSERT(lbl, clk, rst, prop, msg)
`define CSVTP_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ hdl/csvtp_pkg.sv @@
`default_nettype none
package csvtp_pkg;

   // defaults for the top-level parameters
   localparam int MAX_FIELD_CHARS_DEF = 10;
   localparam int FIELD_LIMIT_DEF     = 11;
   localparam int FRACTION_DIGITS_DEF = 5;

   // storage widths
   localparam int ACC_W      = 48;  // position and integer accumulators
   localparam int WEIGHT_W   = 24;  // holds 10**7
   localparam int DIGIT_W    = 4;
   localparam int PROD_W     = WEIGHT_W + DIGIT_W;
   localparam int FIELD_W    = 4;
   localparam int CHAR_CNT_W = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CHAR_CNT_W-1:0] CHAR_CNT_SAT = '1;

   // field numbers with a meaning
   localparam logic [FIELD_W-1:0] FIELD_TIME     = 4'd2;
   localparam logic [FIELD_W-1:0] FIELD_LAT      = 4'd3;
   localparam logic [FIELD_W-1:0] FIELD_LON      = 4'd4;
   localparam logic [FIELD_W-1:0] FIELD_ALT      = 4'd5;
   localparam logic [FIELD_W-1:0] FIELD_COUNT    = 4'd9;
   localparam logic [FIELD_W-1:0] FIELD_STRENGTH = 4'd10;

   // character positions that open the hour, minute and second parts of hhmmss
   localparam logic [CHAR_CNT_W-1:0] TIME_HOUR_POS = 4'd0;
   localparam logic [CHAR_CNT_W-1:0] TIME_MIN_POS  = 4'd2;
   localparam logic [CHAR_CNT_W-1:0] TIME_SEC_POS  = 4'd4;

   // ASCII codes
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      TOK_DIGIT,
      TOK_PLUS,
      TOK_MINUS,
      TOK_POINT,
      TOK_COMMA,
      TOK_OTHER
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type         kind;
      logic [DIGIT_W-1:0]   digit;
      logic                 last;
   } token_type;

   function automatic logic [WEIGHT_W-1:0] pow10(input int unsigned n);
      logic [WEIGHT_W-1:0] v;
      v = WEIGHT_W'(1);
      for (int unsigned i = 0; i < n; i++) begin
         v = WEIGHT_W'(v * WEIGHT_W'(10));
      end
      return v;
   endfunction

endpackage
`default_nettype wire

@@ hdl/csvtp_if.sv @@
`default_nettype none
interface csvtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       record_end;

   modport source (output valid, output char_byte, output record_end, input ready);
   modport sink   (input valid, input char_byte, input record_end, output ready);
endinterface

interface csvtp_rsp_if;
   logic               valid;
   logic               ready;
   logic [6:0]         hour;
   logic [6:0]         minute;
   logic [7:0]         second;
   logic signed [47:0] latitude;
   logic signed [47:0] longitude;
   logic [15:0]        altitude;
   logic [15:0]        messages_received;
   logic signed [7:0]  signal_strength;

   modport source (output valid, output hour, output minute, output second,
                   output latitude, output longitude, output altitude,
                   output messages_received, output signal_strength, input ready);
   modport sink   (input valid, input hour, input minute, input second,
                   input latitude, input longitude, input altitude,
                   input messages_received, input signal_strength, output ready);
endinterface
`default_nettype wire

@@ hdl/csvtp_front.sv @@
`default_nettype none
module csvtp_front (
   csvtp_req_if.sink             req_bus,
   input  logic                  queue_full,
   output logic                  push,
   output csvtp_pkg::token_type  push_token
);
   import csvtp_pkg::*;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   // classify the byte
   always_comb begin
      push_token.last  = req_bus.record_end;
      push_token.digit = DIGIT_W'(req_bus.char_byte - CHAR_ZERO);
      unique case (req_bus.char_byte) inside
         [CHAR_ZERO:CHAR_NINE]: push_token.kind = TOK_DIGIT;
         CHAR_PLUS:             push_token.kind = TOK_PLUS;
         CHAR_MINUS:            push_token.kind = TOK_MINUS;
         CHAR_POINT:            push_token.kind = TOK_POINT;
         CHAR_COMMA:            push_token.kind = TOK_COMMA;
         default:               push_token.kind = TOK_OTHER;
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/csvtp_queue.sv @@
`default_nettype none
`include "csv_telemetry_field_parser_defines.svh"
module csvtp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  csvtp_pkg::token_type  push_token,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output csvtp_pkg::token_type  head
);
   import csvtp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

   token_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == DEPTH_C);
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

   `CSVTP_NEVER(a_push_when_full, clock, reset, push && full, "push into full queue")
   `CSVTP_NEVER(a_pop_when_empty, clock, reset, pop && !head_valid, "pop from empty queue")
   `CSVTP_ASSERT(a_count_bound, clock, reset, count_ff <= DEPTH_C, "queue count past depth")

endmodule
`default_nettype wire

@@ hdl/csvtp_back.sv @@
`default_nettype none
`include "csv_telemetry_field_parser_defines.svh"
module csvtp_back #(
   parameter int MAX_FIELD_CHARS = csvtp_pkg::MAX_FIELD_CHARS_DEF,
   parameter int FIELD_LIMIT     = csvtp_pkg::FIELD_LIMIT_DEF,
   parameter int FRACTION_DIGITS = csvtp_pkg::FRACTION_DIGITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  csvtp_pkg::token_type  head,
   output logic                  pop,
   csvtp_rsp_if.source           rsp_bus
);
   import csvtp_pkg::*;

   localparam int FC_W = $clog2(FRACTION_DIGITS + 1);
   localparam logic [FIELD_W-1:0]    FIELD_LIMIT_C = FIELD_W'(FIELD_LIMIT);
   localparam logic [CHAR_CNT_W-1:0] MAX_CHARS_C   = CHAR_CNT_W'(MAX_FIELD_CHARS);
   localparam logic [FC_W-1:0]       FRAC_MAX_C    = FC_W'(FRACTION_DIGITS);
   localparam logic [WEIGHT_W-1:0]   INT_WEIGHT    = pow10(FRACTION_DIGITS);

   // scan state
   logic [FIELD_W-1:0]    field_num_ff, field_num_in;
   logic [CHAR_CNT_W-1:0] char_cnt_ff, char_cnt_in;
   logic [ACC_W-1:0]      int_acc_ff, int_acc_in;
   logic [ACC_W-1:0]      pos_acc_ff, pos_acc_in;
   logic [FC_W-1:0]       frac_cnt_ff, frac_cnt_in;
   logic                  point_ff, point_in;
   logic                  minus_ff, minus_in;
   logic                  stopped_ff, stopped_in;
   logic [6:0]            hour_p_ff, hour_p_in;
   logic [6:0]            min_p_ff, min_p_in;
   logic [7:0]            sec_p_ff, sec_p_in;

   // kept values
   logic [6:0]       kept_hour_ff, kept_hour_in;
   logic [6:0]       kept_min_ff, kept_min_in;
   logic [7:0]       kept_sec_ff, kept_sec_in;
   logic [ACC_W-1:0] kept_lat_ff, kept_lat_in;
   logic [ACC_W-1:0] kept_lon_ff, kept_lon_in;
   logic [15:0]      kept_alt_ff, kept_alt_in;
   logic [15:0]      kept_count_ff, kept_count_in;
   logic [7:0]       kept_str_ff, kept_str_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [6:0]       rsp_hour_ff;
   logic [6:0]       rsp_min_ff;
   logic [7:0]       rsp_sec_ff;
   logic [ACC_W-1:0] rsp_lat_ff;
   logic [ACC_W-1:0] rsp_lon_ff;
   logic [15:0]      rsp_alt_ff;
   logic [15:0]      rsp_count_ff;
   logic [7:0]       rsp_str_ff;
   logic             load_rsp;

   logic [WEIGHT_W-1:0]   frac_weight;
   logic [PROD_W-1:0]     frac_term;
   logic [PROD_W-1:0]     int_term;
   logic [ACC_W-1:0]      pos_times_ten;
   logic                  is_comma;
   logic                  accepted;
   logic                  takes_point;
   logic [CHAR_CNT_W-1:0] pos;

   // an end beat waits until the output register is free
   assign pop = head_valid && (!head.last || !rsp_valid_ff || rsp_bus.ready);

   // weight of the next fraction digit
   always_comb begin
      frac_weight = '0;
      for (int i = 0; i < FRACTION_DIGITS; i++) begin
         if (frac_cnt_ff == FC_W'(i)) begin
            frac_weight = pow10(FRACTION_DIGITS - 1 - i);
         end
      end
   end

   assign frac_term     = PROD_W'(head.digit) * PROD_W'(frac_weight);
   assign int_term      = PROD_W'(head.digit) * PROD_W'(INT_WEIGHT);
   assign pos_times_ten = {pos_acc_ff[ACC_W-4:0], 3'b000} + {pos_acc_ff[ACC_W-2:0], 1'b0};
   assign takes_point   = (field_num_ff >= FIELD_LAT) && (field_num_ff <= FIELD_ALT);
   assign pos           = char_cnt_ff;
   assign is_comma      = (head.kind == TOK_COMMA);

   always_comb begin
      field_num_in  = field_num_ff;
      char_cnt_in   = char_cnt_ff;
      int_acc_in    = int_acc_ff;
      pos_acc_in    = pos_acc_ff;
      frac_cnt_in   = frac_cnt_ff;
      point_in      = point_ff;
      minus_in      = minus_ff;
      stopped_in    = stopped_ff;
      hour_p_in     = hour_p_ff;
      min_p_in      = min_p_ff;
      sec_p_in      = sec_p_ff;
      kept_hour_in  = kept_hour_ff;
      kept_min_in   = kept_min_ff;
      kept_sec_in   = kept_sec_ff;
      kept_lat_in   = kept_lat_ff;
      kept_lon_in   = kept_lon_ff;
      kept_alt_in   = kept_alt_ff;
      kept_count_in = kept_count_ff;
      kept_str_in   = kept_str_ff;
      accepted      = 1'b0;
      load_rsp      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;

      if (pop) begin
         // scan one character
         if (!is_comma) begin
            if (field_num_ff == FIELD_TIME) begin
               if (pos == TIME_MIN_POS) begin
                  if (minus_in) hour_p_in = ~hour_p_in + 7'd1;
                  minus_in   = 1'b0;
                  stopped_in = 1'b0;
               end
               if (pos == TIME_SEC_POS) begin
                  if (minus_in) min_p_in = ~min_p_in + 7'd1;
                  minus_in   = 1'b0;
                  stopped_in = 1'b0;
               end
               if (!stopped_in) begin
                  if ((pos == TIME_HOUR_POS || pos == TIME_MIN_POS || pos == TIME_SEC_POS)
                      && (head.kind == TOK_PLUS || head.kind == TOK_MINUS)) begin
                     minus_in = (head.kind == TOK_MINUS);
                  end else if (head.kind == TOK_DIGIT) begin
                     if (pos < TIME_MIN_POS) begin
                        hour_p_in = {hour_p_in[3:0], 3'b000} + {hour_p_in[5:0], 1'b0}
                                    + 7'(head.digit);
                     end else if (pos < TIME_SEC_POS) begin
                        min_p_in = {min_p_in[3:0], 3'b000} + {min_p_in[5:0], 1'b0}
                                   + 7'(head.digit);
                     end else begin
                        sec_p_in = {sec_p_in[4:0], 3'b000} + {sec_p_in[6:0], 1'b0}
                                   + 8'(head.digit);
                     end
                  end else begin
                     stopped_in = 1'b1;
                  end
               end
            end else if (!stopped_ff) begin
               if (pos == '0 && (head.kind == TOK_PLUS || head.kind == TOK_MINUS)) begin
                  minus_in = (head.kind == TOK_MINUS);
               end else if (head.kind == TOK_DIGIT) begin
                  if (point_ff) begin
                     if (frac_cnt_ff < FRAC_MAX_C) begin
                        pos_acc_in  = minus_ff ? pos_acc_ff - ACC_W'(frac_term)
                                               : pos_acc_ff + ACC_W'(frac_term);
                        frac_cnt_in = frac_cnt_ff + FC_W'(1);
                     end
                  end else begin
                     int_acc_in = {int_acc_ff[ACC_W-4:0], 3'b000}
                                  + {int_acc_ff[ACC_W-2:0], 1'b0} + ACC_W'(head.digit);
                     pos_acc_in = minus_ff ? pos_times_ten - ACC_W'(int_term)
                                           : pos_times_ten + ACC_W'(int_term);
                  end
               end else if (head.kind == TOK_POINT && takes_point && !point_ff) begin
                  point_in = 1'b1;
               end else begin
                  stopped_in = 1'b1;
               end
            end
            if (char_cnt_ff != CHAR_CNT_SAT) char_cnt_in = char_cnt_ff + CHAR_CNT_W'(1);
         end

         // close the field
         if (is_comma || head.last) begin
            accepted = (field_num_in < FIELD_LIMIT_C) && (char_cnt_in < MAX_CHARS_C);
            if (field_num_in == FIELD_TIME && minus_in) begin
               if (char_cnt_in <= TIME_MIN_POS) begin
                  hour_p_in = ~hour_p_in + 7'd1;
               end else if (char_cnt_in <= TIME_SEC_POS) begin
                  min_p_in = ~min_p_in + 7'd1;
               end else begin
                  sec_p_in = ~sec_p_in + 8'd1;
               end
            end
            if (accepted) begin
               case (field_num_in)
                  FIELD_TIME: begin
                     kept_hour_in = hour_p_in;
                     kept_min_in  = min_p_in;
                     kept_sec_in  = sec_p_in;
                  end
                  FIELD_LAT: begin
                     if (char_cnt_in != '0) kept_lat_in = pos_acc_in;
                  end
                  FIELD_LON: begin
                     if (char_cnt_in != '0) kept_lon_in = pos_acc_in;
                  end
                  FIELD_ALT: begin
                     if (char_cnt_in != '0) begin
                        if (minus_in) kept_alt_in = '0;
                        else if (|int_acc_in[ACC_W-1:16]) kept_alt_in = '1;
                        else kept_alt_in = int_acc_in[15:0];
                     end
                  end
                  FIELD_COUNT: begin
                     kept_count_in = minus_in ? ~int_acc_in[15:0] + 16'd1 : int_acc_in[15:0];
                  end
                  FIELD_STRENGTH: begin
                     kept_str_in = minus_in ? ~int_acc_in[7:0] + 8'd1 : int_acc_in[7:0];
                  end
                  default: ;
               endcase
            end
            if (field_num_in < FIELD_LIMIT_C) field_num_in = field_num_in + FIELD_W'(1);
            char_cnt_in = '0;
            int_acc_in  = '0;
            pos_acc_in  = '0;
            frac_cnt_in = '0;
            point_in    = 1'b0;
            minus_in    = 1'b0;
            stopped_in  = 1'b0;
            hour_p_in   = '0;
            min_p_in    = '0;
            sec_p_in    = '0;
         end

         // a trailing comma leaves an empty last field
         if (is_comma && head.last && field_num_in < FIELD_LIMIT_C) begin
            case (field_num_in)
               FIELD_TIME: begin
                  kept_hour_in = '0;
                  kept_min_in  = '0;
                  kept_sec_in  = '0;
               end
               FIELD_COUNT:    kept_count_in = '0;
               FIELD_STRENGTH: kept_str_in   = '0;
               default: ;
            endcase
         end

         if (head.last) begin
            load_rsp     = 1'b1;
            rsp_valid_in = 1'b1;
            field_num_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_num_ff  <= '0;
         char_cnt_ff   <= '0;
         int_acc_ff    <= '0;
         pos_acc_ff    <= '0;
         frac_cnt_ff   <= '0;
         point_ff      <= 1'b0;
         minus_ff      <= 1'b0;
         stopped_ff    <= 1'b0;
         hour_p_ff     <= '0;
         min_p_ff      <= '0;
         sec_p_ff      <= '0;
         kept_hour_ff  <= '0;
         kept_min_ff   <= '0;
         kept_sec_ff   <= '0;
         kept_lat_ff   <= '0;
         kept_lon_ff   <= '0;
         kept_alt_ff   <= '0;
         kept_count_ff <= '0;
         kept_str_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         field_num_ff  <= field_num_in;
         char_cnt_ff   <= char_cnt_in;
         int_acc_ff    <= int_acc_in;
         pos_acc_ff    <= pos_acc_in;
         frac_cnt_ff   <= frac_cnt_in;
         point_ff      <= point_in;
         minus_ff      <= minus_in;
         stopped_ff    <= stopped_in;
         hour_p_ff     <= hour_p_in;
         min_p_ff      <= min_p_in;
         sec_p_ff      <= sec_p_in;
         kept_hour_ff  <= kept_hour_in;
         kept_min_ff   <= kept_min_in;
         kept_sec_ff   <= kept_sec_in;
         kept_lat_ff   <= kept_lat_in;
         kept_lon_ff   <= kept_lon_in;
         kept_alt_ff   <= kept_alt_in;
         kept_count_ff <= kept_count_in;
         kept_str_ff   <= kept_str_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_hour_ff  <= kept_hour_in;
         rsp_min_ff   <= kept_min_in;
         rsp_sec_ff   <= kept_sec_in;
         rsp_lat_ff   <= kept_lat_in;
         rsp_lon_ff   <= kept_lon_in;
         rsp_alt_ff   <= kept_alt_in;
         rsp_count_ff <= kept_count_in;
         rsp_str_ff   <= kept_str_in;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.hour              = rsp_hour_ff;
   assign rsp_bus.minute            = rsp_min_ff;
   assign rsp_bus.second            = rsp_sec_ff;
   assign rsp_bus.latitude          = $signed(rsp_lat_ff);
   assign rsp_bus.longitude         = $signed(rsp_lon_ff);
   assign rsp_bus.altitude          = rsp_alt_ff;
   assign rsp_bus.messages_received = rsp_count_ff;
   assign rsp_bus.signal_strength   = $signed(rsp_str_ff);

   `CSVTP_ASSERT(a_end_loads_rsp, clock, reset, (pop && head.last) |=> rsp_valid_ff,
                 "record end did not raise response valid")
   `CSVTP_NEVER(a_no_rsp_overwrite, clock, reset,
                pop && head.last && rsp_valid_ff && !rsp_bus.ready,
                "pending response overwritten")
   `CSVTP_ASSERT(a_field_bound, clock, reset, field_num_ff <= FIELD_LIMIT_C,
                 "field counter past limit")

endmodule
`default_nettype wire

@@ hdl/csv_telemetry_field_parser.sv @@
`default_nettype none
// Channel   Direction  Beat carries
// req_bus   in         char_byte, record_end
// rsp_bus   out        hour, minute, second, latitude, longitude, altitude,
//                      messages_received, signal_strength
//
// Takes one byte per cycle while the byte queue is not full; with the queue empty a record's
// last byte is written into the queue, and the parse step then loads the result into the
// output register, where it is presented.
// The rate is set by the parse step: one multiply-by-ten accumulate per byte.
// Reset is synchronous and clears the field counter, scan state and kept values to zero.
// A stalled response holds the parse step on the end beat; the four-entry byte queue
// keeps req_bus ready until it fills.
module csv_telemetry_field_parser #(
   parameter int MAX_FIELD_CHARS = csvtp_pkg::MAX_FIELD_CHARS_DEF,
   parameter int FIELD_LIMIT     = csvtp_pkg::FIELD_LIMIT_DEF,
   parameter int FRACTION_DIGITS = csvtp_pkg::FRACTION_DIGITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   csvtp_req_if.sink     req_bus,
   csvtp_rsp_if.source   rsp_bus
);
   import csvtp_pkg::*;

   // front to queue
   logic      push;
   logic      queue_full;
   token_type push_token;

   // queue to back
   logic      head_valid;
   logic      pop;
   token_type head;

   // classify each byte as it is accepted
   csvtp_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_token (push_token)
   );

   // hold classified bytes so either side can stall
   csvtp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // advance the field parser and deliver one result per record
   csvtp_back #(
      .MAX_FIELD_CHARS (MAX_FIELD_CHARS),
      .FIELD_LIMIT     (FIELD_LIMIT),
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule
`default_nettype wire

@@ bench/csv_telemetry_field_parser_tb.sv @@
`timescale 1ns / 1ps

module csv_telemetry_field_parser_tb;
   import csvtp_pkg::*;

   // Run length and watchdog.
   localparam int unsigned RANDOM_BEATS   = 940;
   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned DRAIN_CYCLES   = 10;

   // One parsed result, in the block's field widths.
   typedef struct packed {
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [7:0]  second;
      logic [47:0] latitude;
      logic [47:0] longitude;
      logic [15:0] altitude;
      logic [15:0] messages_received;
      logic [7:0]  signal_strength;
   } record_fields_type;

   // Scoreboard: tracks the parser state beat by beat and holds the records
   // that are still to come out of the block.
   class telemetry_scoreboard_type;
      logic [3:0]        field_no;
      logic [3:0]        field_chars;
      logic [63:0]       whole_acc;
      logic [63:0]       frac_acc;
      int unsigned       frac_len;
      bit                point_taken;
      bit                negative;
      bit                halted;
      logic [6:0]        hour_part;
      logic [6:0]        minute_part;
      logic [7:0]        second_part;
      record_fields_type held;
      record_fields_type awaited[$];
      int unsigned       mismatches;
      int unsigned       records_checked;

      function new();
         field_no        = '0;
         held            = '0;
         mismatches      = 0;
         records_checked = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         field_chars = '0;
         whole_acc   = '0;
         frac_acc    = '0;
         frac_len    = 0;
         point_taken = 1'b0;
         negative    = 1'b0;
         halted      = 1'b0;
         hour_part   = '0;
         minute_part = '0;
         second_part = '0;
      endfunction

      function bit is_digit(logic [7:0] c);
         return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      endfunction

      // Close one hhmmss part: apply its sign, then let the next part scan.
      function void close_part(int unsigned part);
         if (negative) begin
            case (part)
               0: hour_part = -hour_part;
               1: minute_part = -minute_part;
               default: second_part = -second_part;
            endcase
         end
         negative = 1'b0;
         halted   = 1'b0;
      endfunction

      function void scan_time(logic [7:0] c, logic [3:0] pos);
         int unsigned part;
         logic [7:0]  d;
         if (pos == TIME_MIN_POS) close_part(0);
         if (pos == TIME_SEC_POS) close_part(1);
         part = (pos < TIME_MIN_POS) ? 0 : ((pos < TIME_SEC_POS) ? 1 : 2);
         if (halted) return;
         if ((pos == TIME_HOUR_POS || pos == TIME_MIN_POS || pos == TIME_SEC_POS) &&
             (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            negative = (c == CHAR_MINUS);
            return;
         end
         if (is_digit(c)) begin
            d = c - CHAR_ZERO;
            case (part)
               0: hour_part = 7'(hour_part * 7'd10 + 7'(d));
               1: minute_part = 7'(minute_part * 7'd10 + 7'(d));
               default: second_part = 8'(second_part * 8'd10 + d);
            endcase
            return;
         end
         halted = 1'b1;
      endfunction

      function void scan_number(logic [7:0] c, logic [3:0] pos);
         bit point_ok;
         point_ok = (field_no >= FIELD_LAT) && (field_no <= FIELD_ALT);
         if (halted) return;
         if (pos == 0 && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            negative = (c == CHAR_MINUS);
            return;
         end
         if (is_digit(c)) begin
            if (point_taken) begin
               // digits past the fixed-point resolution are truncated away
               if (frac_len < FRACTION_DIGITS_DEF) begin
                  frac_acc = frac_acc * 64'd10 + 64'(c - CHAR_ZERO);
                  frac_len++;
               end
            end else begin
               whole_acc = whole_acc * 64'd10 + 64'(c - CHAR_ZERO);
            end
            return;
         end
         if (c == CHAR_POINT && point_ok && !point_taken) begin
            point_taken = 1'b1;
            return;
         end
         halted = 1'b1;
      endfunction

      function logic [63:0] ten_to(int unsigned n);
         logic [63:0] v;
         v = 64'd1;
         repeat (n) v = v * 64'd10;
         return v;
      endfunction

      function logic [47:0] position_value();
         logic [63:0] mag;
         mag = whole_acc * ten_to(FRACTION_DIGITS_DEF) +
               frac_acc * ten_to(FRACTION_DIGITS_DEF - frac_len);
         if (negative) mag = -mag;
         return mag[47:0];
      endfunction

      function void end_field();
         bit          taken;
         logic [63:0] signed_whole;
         taken = (field_no < FIELD_LIMIT_DEF) && (field_chars < MAX_FIELD_CHARS_DEF);
         signed_whole = negative ? -whole_acc : whole_acc;
         if (field_no == FIELD_TIME)
            close_part(field_chars <= 2 ? 0 : (field_chars <= 4 ? 1 : 2));
         if (taken) begin
            case (field_no)
               FIELD_TIME: begin
                  held.hour   = hour_part;
                  held.minute = minute_part;
                  held.second = second_part;
               end
               // empty position fields keep their old value
               FIELD_LAT: if (field_chars != 0) held.latitude = position_value();
               FIELD_LON: if (field_chars != 0) held.longitude = position_value();
               FIELD_ALT: if (field_chars != 0) begin
                  if (negative) held.altitude = '0;
                  else if (whole_acc > 64'd65535) held.altitude = 16'hFFFF;
                  else held.altitude = whole_acc[15:0];
               end
               FIELD_COUNT: held.messages_received = signed_whole[15:0];
               FIELD_STRENGTH: held.signal_strength = signed_whole[7:0];
               default: ;
            endcase
         end
         if (field_no < FIELD_LIMIT_DEF) field_no++;
         clear_scan();
      endfunction

      function void note_beat(logic [7:0] c, bit last);
         if (c == CHAR_COMMA) begin
            end_field();
         end else begin
            if (field_no == FIELD_TIME) scan_time(c, field_chars);
            else scan_number(c, field_chars);
            if (field_chars != CHAR_CNT_SAT) field_chars++;
         end
         if (last) begin
            end_field();
            awaited.push_back(held);
            field_no = '0;
            clear_scan();
         end
      endfunction

      task report_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
         mismatches++;
         $display("mismatch on record %0d, %s: got 0x%0h, expected 0x%0h",
                  records_checked, what, got_v, want_v);
      endtask

      task check_record(record_fields_type got);
         record_fields_type want;
         if (awaited.size() == 0) begin
            report_mismatch("result with no record pending", '0, '0);
            return;
         end
         want = awaited.pop_front();
         if (got.hour !== want.hour)
            report_mismatch("hour", 64'(got.hour), 64'(want.hour));
         if (got.minute !== want.minute)
            report_mismatch("minute", 64'(got.minute), 64'(want.minute));
         if (got.second !== want.second)
            report_mismatch("second", 64'(got.second), 64'(want.second));
         if (got.latitude !== want.latitude)
            report_mismatch("latitude", 64'(got.latitude), 64'(want.latitude));
         if (got.longitude !== want.longitude)
            report_mismatch("longitude", 64'(got.longitude), 64'(want.longitude));
         if (got.altitude !== want.altitude)
            report_mismatch("altitude", 64'(got.altitude), 64'(want.altitude));
         if (got.messages_received !== want.messages_received)
            report_mismatch("messages_received", 64'(got.messages_received),
                            64'(want.messages_received));
         if (got.signal_strength !== want.signal_strength)
            report_mismatch("signal_strength", 64'(got.signal_strength),
                            64'(want.signal_strength));
         records_checked++;
      endtask
   endclass

   logic clock;
   logic reset;

   csvtp_req_if req_bus ();
   csvtp_rsp_if rsp_bus ();

   csv_telemetry_field_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   telemetry_scoreboard_type sb;
   record_fields_type        observed;
   logic [7:0]               line_bytes[$];   // bytes of the record being built
   int unsigned              beats_sent   = 0;
   int unsigned              records_sent = 0;
   int unsigned              cycle_count  = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a correct run ends far below this limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d records still pending",
                  cycle_count, sb.awaited.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Both sides run without idling for a stretch of the byte stream.
   function automatic bit calm_window();
      return (beats_sent >= 500) && (beats_sent < 800);
   endfunction

   // Result side: check every accepted beat, then pick ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         observed.hour              = rsp_bus.hour;
         observed.minute            = rsp_bus.minute;
         observed.second            = rsp_bus.second;
         observed.latitude          = rsp_bus.latitude;
         observed.longitude         = rsp_bus.longitude;
         observed.altitude          = rsp_bus.altitude;
         observed.messages_received = rsp_bus.messages_received;
         observed.signal_strength   = rsp_bus.signal_strength;
         sb.check_record(observed);
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm_window() || ($urandom_range(99) >= 29);
      end
   end

   // Present one byte, idling at random first; hold it until the block takes it.
   task automatic send_beat(logic [7:0] c, bit last);
      while (!calm_window() && $urandom_range(99) < 29) begin
         req_bus.valid     <= 1'b0;
         req_bus.char_byte <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.char_byte  <= c;
      req_bus.record_end <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_beat(c, last);
      beats_sent++;
   endtask

   // Send the built record; its last byte carries record_end.
   task automatic send_line();
      for (int i = 0; i < line_bytes.size(); i++) begin
         send_beat(line_bytes[i], i == line_bytes.size() - 1);
      end
      records_sent++;
   endtask

   function automatic void put_char(logic [7:0] c);
      line_bytes.push_back(c);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
   endfunction

   task automatic send_text(string s);
      line_bytes.delete();
      put_text(s);
      send_line();
   endtask

   function automatic logic [7:0] any_digit();
      return CHAR_ZERO + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] any_sign();
      return $urandom_range(1) ? CHAR_MINUS : CHAR_PLUS;
   endfunction

   // Characters that stop a number scan.
   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      case ($urandom_range(5))
         0: c = " ";
         1: c = "E";
         2: c = "n";
         3: c = 8'h00;
         default: c = 8'($urandom_range(128, 255));
      endcase
      return c;
   endfunction

   function automatic logic [7:0] number_char();
      logic [7:0] c;
      case ($urandom_range(4))
         0, 1: c = any_digit();
         2: c = CHAR_POINT;
         3: c = any_sign();
         default: c = junk_char();
      endcase
      return c;
   endfunction

   function automatic logic [7:0] text_char();
      int unsigned r;
      r = $urandom_range(37);
      if (r < 26) return "A" + 8'(r);
      if (r < 36) return any_digit();
      return CHAR_POINT;
   endfunction

   function automatic void put_digits(int unsigned n);
      repeat (n) put_char(any_digit());
   endfunction

   function automatic void put_sign_maybe();
      case ($urandom_range(5))
         0, 1: put_char(CHAR_MINUS);
         2: put_char(CHAR_PLUS);
         default: ;
      endcase
   endfunction

   function automatic void put_time_field();
      case ($urandom_range(9))
         0: ;
         1: repeat ($urandom_range(1, 5))
               put_char($urandom_range(3) == 0 ? any_sign() : any_digit());
         2: repeat (3) begin
               // each hhmmss part may open with its own sign
               put_char($urandom_range(1) ? any_sign() : any_digit());
               put_char(any_digit());
            end
         8: begin
            put_digits(2);
            put_char(junk_char());
            put_digits($urandom_range(4));
         end
         9: put_digits($urandom_range(10, 14));
         default: begin
            put_digits(6 + $urandom_range(2));
            if ($urandom_range(3) == 0) begin
               put_char(CHAR_POINT);
               put_digits(2);
            end
         end
      endcase
   endfunction

   function automatic void put_position_field(int unsigned int_max);
      case ($urandom_range(11))
         0: ;
         1: begin
            put_digits(5);
            put_char(CHAR_POINT);
            put_digits($urandom_range(5, 8));
         end
         2: repeat ($urandom_range(1, 9)) put_char(number_char());
         default: begin
            put_sign_maybe();
            put_digits($urandom_range(int_max));
            if ($urandom_range(9) < 7) begin
               put_char(CHAR_POINT);
               put_digits($urandom_range(7));
            end
         end
      endcase
   endfunction

   function automatic void put_integer_field();
      case ($urandom_range(7))
         0: ;
         1: repeat ($urandom_range(1, 6)) put_char(number_char());
         default: begin
            put_sign_maybe();
            put_digits($urandom_range(1, 7));
            if ($urandom_range(5) == 0) put_char(junk_char());
         end
      endcase
   endfunction

   // Mostly well-formed records with random content; some raw noise and some
   // records cut short at a random byte.
   function automatic void build_random_record();
      int unsigned shape;
      int unsigned pick;
      int unsigned nfields;
      int unsigned keep;
      line_bytes.delete();
      shape = $urandom_range(99);
      if (shape < 15) begin
         repeat ($urandom_range(1, 24)) begin
            if ($urandom_range(5) == 0) put_char(CHAR_COMMA);
            else put_char(8'($urandom_range(255)));
         end
      end else begin
         pick = $urandom_range(99);
         nfields = (pick < 65) ? 11 : ((pick < 80) ? $urandom_range(12, 15)
                                                   : $urandom_range(1, 10));
         for (int f = 0; f < nfields; f++) begin
            if (f > 0) put_char(CHAR_COMMA);
            if ($urandom_range(15) == 0) begin
               put_digits($urandom_range(10, 13));   // too long, dropped
            end else begin
               case (f)
                  FIELD_TIME: put_time_field();
                  FIELD_LAT: put_position_field(4);
                  FIELD_LON: put_position_field(5);
                  FIELD_ALT: put_position_field(6);
                  FIELD_COUNT, FIELD_STRENGTH: put_integer_field();
                  default: repeat ($urandom_range(6)) put_char(text_char());
               endcase
            end
         end
         if ($urandom_range(9) == 0) put_char(CHAR_COMMA);
         if (shape >= 85 && line_bytes.size() > 1) begin
            keep = $urandom_range(1, line_bytes.size());
            while (line_bytes.size() > keep) void'(line_bytes.pop_back());
         end
      end
      if (line_bytes.size() == 0) put_char(any_digit());
   endfunction

   task automatic run_directed();
      // typical record with count and strength at their extremes
      send_text("$GPGGA,7,123519,4807.0381,-1131.000,545.4,M,8,0.9,65535,-128");
      // empty time clears it; empty positions hold; empty count/strength give zero;
      // the comma on the last byte opens one more empty field
      send_text("a,b,,,,,x,y,z,,");
      // signed time parts, extra fraction digits, negative altitude, wraps
      send_text(",,-1-2-3,9.9999999,-.1234567,-5,,,,+300,-129");
      // fields of ten characters are ignored; altitude saturates
      send_text(",,1234567890,1234567890,12345678901,99999,,,,9999999,255");
      // fields past the limit are ignored
      send_text("0,1,2,3,4,5,6,7,8,9,10,11,12,13,14");
      // byte zero, top-bit bytes and leading whitespace stop the scan
      line_bytes.delete();
      put_text(",,");
      put_char(8'h00);
      put_text("12,");
      put_char(8'hFF);
      put_text("1, 12,+,.,,,,12");
      put_char(8'h00);
      put_char("3");
      send_line();
      // one-byte records
      send_text("5");
      send_text(",");
      // short and broken time fields
      send_text(",,12");
      send_text(",,12+3456.7");
      send_text(",,1x3456");
      // fraction only, lone sign and lone point
      send_text(",,,+.5,-,.");
      // large magnitudes at and just past the field limits
      send_text(",,99-99-9,-9999.9999,-99999999,65536,,,,-1,127");
   endtask

   initial begin
      int unsigned directed_beats;
      int unsigned directed_records;
      sb = new();
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.char_byte  <= 8'h00;
      req_bus.record_end <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      directed_beats   = beats_sent;
      directed_records = records_sent;

      while ((beats_sent - directed_beats) < RANDOM_BEATS) begin
         build_random_record();
         send_line();
      end
      req_bus.valid <= 1'b0;

      // drain: wait for every pending record, then let the pipeline settle
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d records (%0d directed), compared %0d results.",
               beats_sent, records_sent, directed_records, sb.records_checked);
      $display("Mismatches: %0d.", sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/csvtp_pkg.sv
hdl/csvtp_if.sv
hdl/csvtp_front.sv
hdl/csvtp_queue.sv
hdl/csvtp_back.sv
hdl/csv_telemetry_field_parser.sv
bench/csv_telemetry_field_parser_tb.sv
